>>> rtl/clkd_pkg.sv
// Shared types, constants and helpers of the click and double-click detector.
package clkd_pkg;

  localparam int unsigned NUM_BUTTONS = 3;
  localparam int unsigned TimeW       = 16;
  localparam int unsigned ButtonW     = 2;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned NumKinds    = 4;

  localparam logic [TimeW-1:0] ClickLimitReset  = TimeW'(300);
  localparam logic [TimeW-1:0] DClickLimitReset = TimeW'(300);

  typedef enum logic [0:0] {
    CMD_TICK      = 1'b0,
    CMD_INTERCEPT = 1'b1
  } cmd_e;

  // The code of each kind is also its bit position in the pending-event mask.
  typedef enum logic [1:0] {
    KIND_DOWN   = 2'd0,
    KIND_DCLICK = 2'd1,
    KIND_CLICK  = 2'd2,
    KIND_UP     = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CLICK_LIMIT  = 2'd0,
    REG_DCLICK_LIMIT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [ButtonW-1:0]  button;
    logic [TimeW-1:0]    time_delta_ms;
    logic                held;
    logic                just_pressed;
    logic                just_released;
    logic                in_window;
    logic [15:0]         pos_x;
    logic [15:0]         pos_y;
    logic signed [15:0]  move_x;
    logic signed [15:0]  move_y;
  } sample_t;

  typedef struct packed {
    kind_e               event_kind;
    logic [ButtonW-1:0]  event_button;
    logic [15:0]         event_x;
    logic [15:0]         event_y;
    logic signed [15:0]  event_dx;
    logic signed [15:0]  event_dy;
    logic                last;
  } event_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [TimeW-1:0]   data;
  } cfg_t;

  // Per-button timers and intercept flag.
  typedef struct packed {
    logic [TimeW-1:0] held_time;
    logic [TimeW-1:0] since_click_time;
    logic             intercept_pending;
  } btn_state_t;

  typedef logic [NumKinds-1:0] kind_mask_t;

  function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                               input logic [TimeW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeW] ? {TimeW{1'b1}} : s[TimeW-1:0];
  endfunction

endpackage

>>> rtl/clkd_if.sv
// Valid/ready channel interfaces for samples, events and register writes.
interface clkd_sample_if import clkd_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface clkd_event_if import clkd_pkg::*; ();
  logic   valid;
  logic   ready;
  event_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface clkd_cfg_if import clkd_pkg::*; ();
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/clkd_step.sv
// Per-button state update and event selection for one sample word.
module clkd_step import clkd_pkg::*; (
  input  sample_t          sample_i,
  input  btn_state_t       state_i,
  input  logic [TimeW-1:0] click_limit_i,
  input  logic [TimeW-1:0] dclick_limit_i,
  output btn_state_t       state_o,
  output kind_mask_t       mask_o
);

  logic [TimeW-1:0] ht_press, ht_held;
  logic [TimeW-1:0] sct_click;
  logic             release_in;
  logic             is_click;
  logic             is_dclick;

  always_comb begin
    ht_press   = sample_i.just_pressed ? '0 : state_i.held_time;
    ht_held    = sample_i.held ? sat_add(ht_press, sample_i.time_delta_ms) : ht_press;
    release_in = sample_i.just_released && sample_i.in_window;
    is_click   = release_in && (ht_held < click_limit_i);
    is_dclick  = is_click && (state_i.since_click_time != '0) &&
                 (state_i.since_click_time < dclick_limit_i);
    if (is_dclick) begin
      sct_click = '0;
    end else if (is_click) begin
      sct_click = sample_i.time_delta_ms;
    end else begin
      sct_click = state_i.since_click_time;
    end
  end

  always_comb begin
    state_o = state_i;
    mask_o  = '0;
    if (sample_i.cmd == CMD_INTERCEPT) begin
      state_o.intercept_pending = 1'b1;
    end else if (state_i.intercept_pending) begin
      // An intercepted sample only clears the flag and preloads both timers to their limits.
      state_o.intercept_pending = 1'b0;
      state_o.held_time         = click_limit_i;
      state_o.since_click_time  = dclick_limit_i;
    end else begin
      state_o.held_time        = release_in ? '0 : ht_held;
      state_o.since_click_time = (sct_click != '0) ?
                                 sat_add(sct_click, sample_i.time_delta_ms) : sct_click;
      mask_o[KIND_DOWN]   = sample_i.held;
      mask_o[KIND_DCLICK] = is_dclick;
      mask_o[KIND_CLICK]  = is_click;
      mask_o[KIND_UP]     = release_in;
    end
  end

endmodule

>>> rtl/click_double_click_detector.sv
// Click and double-click detector: pointer button samples in, click events out.
//
// Each accepted sample word updates its button's timers in the cycle it is
// taken and loads the events it causes (down, double click, click, up, in that
// order) into a result register, which sends them one word per cycle while
// the output is ready, with last set on the final one. A sample is taken every
// cycle as long as no event is pending or the final pending event leaves in
// that cycle, so a sample that causes events holds the input until its final
// event leaves the single event output register.
// Samples that cause no event, intercept commands and samples for buttons out
// of range wait for the input to open like any other sample, but they load
// nothing into the result register. Register writes are always taken.
module click_double_click_detector import clkd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  clkd_sample_if.sink         in_i,
  clkd_event_if.source        out_o,
  clkd_cfg_if.sink            cfg_i
);

  logic [TimeW-1:0] click_limit_q, dclick_limit_q;
  btn_state_t       state_q [NUM_BUTTONS];
  btn_state_t       cur_state, next_state;
  kind_mask_t       new_mask;
  kind_mask_t       mask_q, mask_rest;
  logic [ButtonW-1:0] res_btn_q;
  logic [15:0]      res_x_q, res_y_q;
  logic signed [15:0] res_dx_q, res_dy_q;
  logic             btn_ok;
  logic             in_fire, out_fire, out_last;
  kind_e            cur_kind;

  assign btn_ok    = 32'(in_i.data.button) < NUM_BUTTONS;
  assign cur_state = btn_ok ? state_q[in_i.data.button] : '0;

  clkd_step u_step (
    .sample_i       (in_i.data),
    .state_i        (cur_state),
    .click_limit_i  (click_limit_q),
    .dclick_limit_i (dclick_limit_q),
    .state_o        (next_state),
    .mask_o         (new_mask)
  );

  assign mask_rest  = mask_q & (mask_q - kind_mask_t'(1));
  assign out_last   = (mask_rest == '0);
  assign out_o.valid = (mask_q != '0);
  assign out_fire   = out_o.valid && out_o.ready;
  assign in_i.ready = (mask_q == '0) || (out_o.ready && out_last);
  assign in_fire    = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    if (mask_q[KIND_DOWN]) begin
      cur_kind = KIND_DOWN;
    end else if (mask_q[KIND_DCLICK]) begin
      cur_kind = KIND_DCLICK;
    end else if (mask_q[KIND_CLICK]) begin
      cur_kind = KIND_CLICK;
    end else begin
      cur_kind = KIND_UP;
    end
  end

  assign out_o.data.event_kind   = cur_kind;
  assign out_o.data.event_button = res_btn_q;
  assign out_o.data.event_x      = res_x_q;
  assign out_o.data.event_y      = res_y_q;
  assign out_o.data.event_dx     = res_dx_q;
  assign out_o.data.event_dy     = res_dy_q;
  assign out_o.data.last         = out_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      click_limit_q  <= ClickLimitReset;
      dclick_limit_q <= DClickLimitReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        REG_CLICK_LIMIT:  click_limit_q  <= cfg_i.data.data;
        REG_DCLICK_LIMIT: dclick_limit_q <= cfg_i.data.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        state_q[i] <= '0;
      end
    end else if (in_fire && btn_ok) begin
      state_q[in_i.data.button] <= next_state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (in_fire && btn_ok && (new_mask != '0)) begin
      mask_q <= new_mask;
    end else if (out_fire) begin
      mask_q <= mask_rest;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && btn_ok && (new_mask != '0)) begin
      res_btn_q <= in_i.data.button;
      res_x_q   <= in_i.data.pos_x;
      res_y_q   <= in_i.data.pos_y;
      res_dx_q  <= in_i.data.move_x;
      res_dy_q  <= in_i.data.move_y;
    end
  end

  // Sending a word that is not the last of its sample removes exactly one pending event.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !out_last) |=>
      (out_o.valid && ($countones(mask_q) == $countones($past(mask_q)) - 1)))
    else $error("event sequence lost or repeated a word");

  // The input only stalls behind a pending result whose final word is not leaving in that cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && (!out_last || !out_o.ready)))
    else $error("input stalled without a pending result");

  // A tick on an intercepted button clears the flag and sends nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && btn_ok && (in_i.data.cmd == CMD_TICK) && cur_state.intercept_pending)
      |-> (new_mask == '0))
    else $error("intercepted sample produced events");

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the click and double-click detector.
`timescale 1ns / 1ps

module tb_top;
  import clkd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned ITEMS_PER_PHASE = 60;
  localparam int unsigned NUM_PHASES = 6;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned SETTLE_CYCLES = 8;

  localparam int BTN_LEFT   = 0;
  localparam int BTN_RIGHT  = 1;
  localparam int BTN_MIDDLE = 2;
  localparam int BTN_NONE   = 3;

  localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;

  logic clk;
  logic rst_n;

  clkd_sample_if in_if ();
  clkd_event_if  ev_if ();
  clkd_cfg_if    cfg_if ();

  click_double_click_detector dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (ev_if),
    .cfg_i  (cfg_if)
  );

  // Predicted state of the block.
  logic [TimeW-1:0] click_lim_ms;
  logic [TimeW-1:0] dclick_lim_ms;
  logic [TimeW-1:0] press_ms  [NUM_BUTTONS];
  logic [TimeW-1:0] gap_ms    [NUM_BUTTONS];
  logic             swallow_next [NUM_BUTTONS];

  sample_t     samples_to_send[$];
  event_t      pending_events[$];
  int unsigned samples_queued;
  int unsigned failures;
  int unsigned cycle_count;
  int unsigned send_gap;
  int unsigned stall_left;
  int          last_button;
  bit          quiet;
  logic        sample_taken;
  logic        cfg_taken;

  initial begin
    clk = 1'b0;
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit chance(input int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // Mostly short gaps, now and then a long one; none at all in a quiet phase.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [TimeW-1:0] add_clamped(input logic [TimeW-1:0] a,
                                                   input logic [TimeW-1:0] b);
    logic [TimeW:0] total;
    total = {1'b0, a} + {1'b0, b};
    if (total > {1'b0, {TimeW{1'b1}}}) return {TimeW{1'b1}};
    return total[TimeW-1:0];
  endfunction

  function automatic event_t make_event(input kind_e kind, input sample_t s);
    event_t e;
    e.event_kind   = kind;
    e.event_button = s.button;
    e.event_x      = s.pos_x;
    e.event_y      = s.pos_y;
    e.event_dx     = s.move_x;
    e.event_dy     = s.move_y;
    e.last         = 1'b0;
    return e;
  endfunction

  function automatic string fmt_event(input event_t e);
    return $sformatf("kind=%0d btn=%0d x=%0d y=%0d dx=%0d dy=%0d last=%0b",
                     e.event_kind, e.event_button, e.event_x, e.event_y,
                     e.event_dx, e.event_dy, e.last);
  endfunction

  function automatic void report(input string msg);
    failures++;
    if (failures <= MAX_REPORTS) $display("tb_top: mismatch: %s", msg);
  endfunction

  // Updates the predicted timers and queues the events one sample word causes.
  function automatic void predict_events(input sample_t s);
    event_t          evs[$];
    int              b;
    logic [TimeW-1:0] dt;
    b  = int'(s.button);
    dt = s.time_delta_ms;
    if (b >= NUM_BUTTONS) return;
    if (s.cmd == CMD_INTERCEPT) begin
      swallow_next[b] = 1'b1;
      return;
    end
    if (swallow_next[b]) begin
      swallow_next[b] = 1'b0;
      press_ms[b]     = click_lim_ms;
      gap_ms[b]       = dclick_lim_ms;
      return;
    end
    if (s.just_pressed) press_ms[b] = '0;
    if (s.held) begin
      press_ms[b] = add_clamped(press_ms[b], dt);
      evs.insert(evs.size(), make_event(KIND_DOWN, s));
    end
    if (s.just_released && s.in_window) begin
      if (press_ms[b] < click_lim_ms) begin
        if (gap_ms[b] != '0 && gap_ms[b] < dclick_lim_ms) begin
          gap_ms[b] = '0;
          evs.insert(evs.size(), make_event(KIND_DCLICK, s));
        end else begin
          gap_ms[b] = dt;
        end
        evs.insert(evs.size(), make_event(KIND_CLICK, s));
      end
      press_ms[b] = '0;
      evs.insert(evs.size(), make_event(KIND_UP, s));
    end
    if (gap_ms[b] != '0) gap_ms[b] = add_clamped(gap_ms[b], dt);
    if (evs.size() > 0) evs[evs.size() - 1].last = 1'b1;
    foreach (evs[i]) pending_events.insert(pending_events.size(), evs[i]);
  endfunction

  function automatic logic [TimeW-1:0] rand_delta();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return TimeW'($urandom_range(0, 120));
    if (r < 90) return TimeW'($urandom_range(0, 600));
    if (r < 97) return TimeW'($urandom_range(0, 5000));
    return TimeW'($urandom_range(0, 65535));
  endfunction

  function automatic sample_t tick(input int b, input logic [TimeW-1:0] dt, input bit held,
                                   input bit pressed, input bit released, input bit win);
    sample_t s;
    s.cmd           = CMD_TICK;
    s.button        = ButtonW'(b);
    s.time_delta_ms = dt;
    s.held          = held;
    s.just_pressed  = pressed;
    s.just_released = released;
    s.in_window     = win;
    s.pos_x         = 16'($urandom);
    s.pos_y         = 16'($urandom);
    s.move_x        = 16'($urandom);
    s.move_y        = 16'($urandom);
    return s;
  endfunction

  function automatic sample_t intercept(input int b);
    sample_t s;
    s     = tick(b, rand_delta(), chance(50), chance(50), chance(50), chance(50));
    s.cmd = CMD_INTERCEPT;
    return s;
  endfunction

  function automatic void queue_sample(input sample_t s);
    samples_to_send.insert(samples_to_send.size(), s);
    if (int'(s.button) < NUM_BUTTONS) samples_queued++;
  endfunction

  // A press, some held ticks, a release and a few quiet ticks on one button.
  function automatic void queue_click_seq(input int b);
    int unsigned holds;
    int unsigned rests;
    bit          tap;
    tap = chance(15);
    queue_sample(tick(b, rand_delta(), 1'b1, 1'b1, tap, chance(90)));
    if (!tap) begin
      holds = $urandom_range(0, 3);
      repeat (holds) queue_sample(tick(b, rand_delta(), 1'b1, chance(5), 1'b0, chance(90)));
      queue_sample(tick(b, rand_delta(), chance(15), 1'b0, 1'b1, chance(85)));
    end
    rests = $urandom_range(0, 2);
    repeat (rests) queue_sample(tick(b, rand_delta(), 1'b0, 1'b0, 1'b0, chance(90)));
  endfunction

  function automatic void queue_noise();
    sample_t s;
    s = tick($urandom_range(0, 3), TimeW'($urandom), chance(50), chance(50), chance(50),
             chance(50));
    s.cmd = cmd_e'($urandom_range(0, 1));
    queue_sample(s);
  endfunction

  function automatic void queue_random_burst();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!chance(60)) last_button = $urandom_range(0, NUM_BUTTONS - 1);
    if (r < 70) begin
      queue_click_seq(last_button);
    end else if (r < 82) begin
      queue_sample(intercept(last_button));
      queue_click_seq(last_button);
    end else begin
      repeat ($urandom_range(1, 3)) queue_noise();
    end
  endfunction

  // Sample driver: a word stays on the bus until it is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (sample_taken) begin
        samples_to_send.delete(0);
        send_gap = pick_gap();
      end
      if (!(in_if.valid && !sample_taken)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_if.valid <= 1'b0;
        end else if (samples_to_send.size() > 0) begin
          in_if.valid <= 1'b1;
          in_if.data  <= samples_to_send[0];
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Event sink with random back-pressure.
  always @(negedge clk) begin
    if (!rst_n) begin
      ev_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      ev_if.ready <= 1'b0;
    end else begin
      ev_if.ready <= 1'b1;
      if (chance(25)) stall_left = pick_gap();
    end
  end

  // Prediction on accepted words and checking of events, both at the rising edge.
  always @(posedge clk) begin : monitor
    event_t got;
    event_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      sample_taken <= rst_n && in_if.valid && in_if.ready;
      cfg_taken    <= rst_n && cfg_if.valid && cfg_if.ready;
      if (rst_n && in_if.valid && in_if.ready) predict_events(in_if.data);
      if (rst_n && cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.data.index)
          REG_CLICK_LIMIT:  click_lim_ms  = cfg_if.data.data;
          REG_DCLICK_LIMIT: dclick_lim_ms = cfg_if.data.data;
          default: ;
        endcase
      end
      if (rst_n && ev_if.valid && ev_if.ready) begin
        got = ev_if.data;
        if (pending_events.size() == 0) begin
          report($sformatf("unexpected event %s", fmt_event(got)));
        end else begin
          want = pending_events[0];
          pending_events.delete(0);
          if (got.event_kind !== want.event_kind || got.event_button !== want.event_button ||
              got.event_x !== want.event_x || got.event_y !== want.event_y ||
              got.event_dx !== want.event_dx || got.event_dy !== want.event_dy ||
              got.last !== want.last)
            report($sformatf("expected %s, got %s", fmt_event(want), fmt_event(got)));
        end
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TimeW-1:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= cfg_t'{index: idx, data: val};
    do @(negedge clk); while (!cfg_taken);
    cfg_if.valid <= 1'b0;
  endtask

  // Waits for every queued word to go out and every predicted event to come back,
  // then lets the block settle so that an event-free sample cannot race a write.
  task automatic wait_drained();
    do @(negedge clk);
    while (samples_to_send.size() != 0 || in_if.valid || pending_events.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [TimeW-1:0] click_tab  [NUM_PHASES];
    logic [TimeW-1:0] dclick_tab [NUM_PHASES];
    sample_t          s;
    int unsigned      target;

    in_if.valid   = 1'b0;
    in_if.data    = '0;
    ev_if.ready   = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    sample_taken  = 1'b0;
    cfg_taken     = 1'b0;
    quiet         = 1'b0;
    last_button   = BTN_LEFT;
    click_lim_ms  = ClickLimitReset;
    dclick_lim_ms = DClickLimitReset;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      press_ms[i]     = '0;
      gap_ms[i]       = '0;
      swallow_next[i] = 1'b0;
    end

    rst_n = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // Directed part with the reset limits of 300 ms.
    s = tick(BTN_LEFT, '0, 1'b1, 1'b1, 1'b0, 1'b1);
    s.pos_x  = '0;
    s.pos_y  = '0;
    s.move_x = 16'sh8000;
    s.move_y = 16'sh8000;
    queue_sample(s);
    queue_sample(tick(BTN_LEFT, 16'd100, 1'b1, 1'b0, 1'b0, 1'b1));
    s = tick(BTN_LEFT, 16'd10, 1'b0, 1'b0, 1'b1, 1'b1);
    s.pos_x  = '1;
    s.pos_y  = '1;
    s.move_x = 16'sh7fff;
    s.move_y = 16'sh7fff;
    queue_sample(s);
    queue_sample(tick(BTN_LEFT, 16'd50, 1'b1, 1'b1, 1'b0, 1'b1));
    // Second quick click on the same button gives a double click.
    queue_sample(tick(BTN_LEFT, 16'd20, 1'b0, 1'b0, 1'b1, 1'b1));
    // A tap within one tick, then a second one that yields all four events.
    queue_sample(tick(BTN_RIGHT, 16'd5, 1'b1, 1'b1, 1'b1, 1'b1));
    queue_sample(tick(BTN_RIGHT, 16'd5, 1'b1, 1'b1, 1'b1, 1'b1));
    // Release outside the window keeps the held time; a long press is no click.
    queue_sample(tick(BTN_MIDDLE, 16'd400, 1'b1, 1'b1, 1'b0, 1'b1));
    queue_sample(tick(BTN_MIDDLE, '0, 1'b0, 1'b0, 1'b1, 1'b0));
    queue_sample(tick(BTN_MIDDLE, '0, 1'b0, 1'b0, 1'b1, 1'b1));
    // The intercepted sample is swallowed and preloads both timers.
    queue_sample(intercept(BTN_LEFT));
    queue_sample(tick(BTN_LEFT, 16'd7, 1'b1, 1'b1, 1'b1, 1'b1));
    queue_sample(tick(BTN_LEFT, '0, 1'b0, 1'b0, 1'b1, 1'b1));
    // A button index out of range is ignored for both commands.
    queue_sample(tick(BTN_NONE, 16'd1, 1'b1, 1'b1, 1'b1, 1'b1));
    queue_sample(intercept(BTN_NONE));
    // Held time and since-click time both saturate.
    queue_sample(tick(BTN_RIGHT, '1, 1'b1, 1'b1, 1'b0, 1'b1));
    queue_sample(tick(BTN_RIGHT, '1, 1'b1, 1'b0, 1'b0, 1'b1));
    queue_sample(tick(BTN_RIGHT, '1, 1'b0, 1'b0, 1'b1, 1'b1));
    queue_sample(tick(BTN_MIDDLE, 16'd1, 1'b1, 1'b1, 1'b1, 1'b1));
    queue_sample(tick(BTN_MIDDLE, '1, 1'b0, 1'b0, 1'b0, 1'b0));
    queue_sample(tick(BTN_MIDDLE, '1, 1'b0, 1'b0, 1'b0, 1'b1));
    queue_sample(tick(BTN_MIDDLE, '0, 1'b0, 1'b0, 1'b1, 1'b1));
    wait_drained();

    click_tab  = '{16'd0, 16'hffff, 16'd150, 16'hffff, TimeW'($urandom), 16'd300};
    dclick_tab = '{16'd0, 16'hffff, 16'd400, 16'd0, TimeW'($urandom), 16'd300};
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(REG_CLICK_LIMIT, click_tab[p]);
      write_reg(REG_DCLICK_LIMIT, dclick_tab[p]);
      if (p == 2) write_reg(REG_UNUSED, TimeW'($urandom));
      quiet  = (p == 3);
      target = samples_queued + ITEMS_PER_PHASE;
      while (samples_queued < target) queue_random_burst();
      wait_drained();
    end

    while (pending_events.size() != 0) begin
      report($sformatf("missing event %s", fmt_event(pending_events[0])));
      pending_events.delete(0);
    end
    if (failures == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
